// File: design/lpsw_pkg.sv
// ---------------------------------------------------------------------------
// LCD pixel and span writer package
// Shared constants, register codes, sequencer states, the output beat type
// and the divide-by-six helper.
// ---------------------------------------------------------------------------
`default_nettype none

package lpsw_pkg;

	localparam int WIDTH_PIXELS_DEF = 240;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0] GRAPHICS_BASE_RST = 16'h0280;
	localparam logic [7:0]  ROW_BYTES_RST     = 8'd40;

	localparam logic [7:0] CMD_SET_ADDR   = 8'h24;
	localparam logic [7:0] CMD_AUTO_WRITE = 8'hB0;
	localparam logic [7:0] CMD_AUTO_RESET = 8'hB2;
	localparam logic [7:0] CMD_BIT_SET    = 8'hF8;
	localparam logic [7:0] CMD_BIT_CLEAR  = 8'hF0;
	localparam logic [7:0] MASK_START     = 8'h3F;
	localparam logic [7:0] BYTE_FULL      = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRAPHICS_BASE = 1'b0,
		REG_ROW_BYTES     = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_MAC,
		ST_ADDQ,
		ST_ADDR_LO,
		ST_ADDR_HI,
		ST_SET_ADDR,
		ST_PIXEL,
		ST_AUTO_WRITE,
		ST_FIRST,
		ST_MID,
		ST_LAST_BYTE,
		ST_AUTO_RESET
	} seq_state_t;

	typedef struct packed {
		logic       is_command;
		logic [7:0] bus_byte;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [5:0] q;
		logic [2:0] r;
	} div6_t;

	// Quotient by multiplication with 171/1024, exact for every 8-bit value.
	function automatic div6_t div6(input logic [7:0] x);
		logic [17:0] prod;
		logic [8:0]  rem;
		div6_t       res;
		prod  = {10'd0, x} * 18'd171;
		res.q = prod[15:10];
		rem   = {1'b0, x} - ({3'd0, res.q} * 9'd6);
		res.r = rem[2:0];
		return res;
	endfunction

endpackage

`default_nettype wire

// File: design/lpsw_alu.sv
// ---------------------------------------------------------------------------
// LCD pixel and span writer shared adder
// The single 16-bit adder that the sequencer uses for the address
// multiply-accumulate, the column offset and the column counter.
// ---------------------------------------------------------------------------
`default_nettype none

module lpsw_alu (
	input  wire logic [15:0] a,
	input  wire logic [15:0] b,
	output logic [15:0]      y
);

	assign y = a + b;

endmodule

`default_nettype wire

// File: design/lpsw_seq.sv
// ---------------------------------------------------------------------------
// LCD pixel and span writer sequencer
// Captures a request, builds the display address with shift-and-add steps
// on the shared adder and then walks through the byte writes one per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module lpsw_seq
	import lpsw_pkg::*;
#(
	parameter int WIDTH_PIXELS = WIDTH_PIXELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        action,
	input  wire logic [7:0]  x_start,
	input  wire logic [7:0]  x_end,
	input  wire logic [6:0]  row,
	input  wire logic        paint,
	input  wire logic [15:0] graphics_base,
	input  wire logic [7:0]  row_bytes,
	input  wire logic        slot_free,
	output logic             emit_valid,
	output beat_t            emit
);

	localparam logic [7:0] XMAX = 8'(WIDTH_PIXELS - 1);

	seq_state_t state_q, state_d;

	logic        action_q;
	logic        paint_q;
	logic [6:0]  row_q;
	logic [7:0]  xs_q;
	logic [7:0]  xe_q;
	logic [5:0]  qs_q;
	logic [2:0]  rs_q;
	logic [5:0]  qe_q;
	logic [2:0]  re_q;
	logic [15:0] acc_q;
	logic [5:0]  col_q;
	logic [2:0]  step_q;

	logic [7:0]  xs_c;
	logic [7:0]  xe_c;
	logic [7:0]  xe_ord;
	div6_t       ds;
	div6_t       de;
	logic [15:0] alu_a;
	logic [15:0] alu_b;
	logic [15:0] alu_y;
	logic        col_load;
	logic [7:0]  start_mask;
	logic [7:0]  end_mask;

	lpsw_alu u_alu (
		.a(alu_a),
		.b(alu_b),
		.y(alu_y)
	);

	assign xs_c       = (x_start > XMAX) ? XMAX : x_start;
	assign xe_c       = (x_end > XMAX) ? XMAX : x_end;
	assign xe_ord     = (xe_c < xs_c) ? xs_c : xe_c;
	assign ds         = div6(xs_q);
	assign de         = div6(xe_q);
	assign start_mask = MASK_START >> rs_q;
	assign end_mask   = BYTE_FULL << (3'd5 - re_q);
	assign in_ready   = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					action_q <= action;
					paint_q  <= paint;
					row_q    <= row;
					xs_q     <= xs_c;
					xe_q     <= xe_ord;
				end
			end
			ST_PREP: begin
				qs_q   <= ds.q;
				rs_q   <= ds.r;
				qe_q   <= de.q;
				re_q   <= de.r;
				acc_q  <= graphics_base;
				step_q <= 3'd0;
			end
			ST_MAC: begin
				acc_q  <= alu_y;
				step_q <= step_q + 3'd1;
			end
			ST_ADDQ: begin
				acc_q <= alu_y;
			end
			default: begin
				if (col_load) begin
					col_q <= alu_y[5:0];
				end
			end
		endcase
	end

	always_comb begin
		state_d    = state_q;
		emit_valid = 1'b0;
		emit       = '{is_command: 1'b0, bus_byte: 8'h00, last: 1'b0};
		alu_a      = acc_q;
		alu_b      = 16'd0;
		col_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_MAC;
			end
			ST_MAC: begin
				alu_b = row_q[step_q] ? (16'(row_bytes) << step_q) : 16'd0;
				if (step_q == 3'd6) begin
					state_d = ST_ADDQ;
				end
			end
			ST_ADDQ: begin
				alu_b   = 16'(qs_q);
				state_d = ST_ADDR_LO;
			end
			ST_ADDR_LO: begin
				emit.bus_byte = acc_q[7:0];
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_ADDR_HI;
				end
			end
			ST_ADDR_HI: begin
				emit.bus_byte = acc_q[15:8];
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_SET_ADDR;
				end
			end
			ST_SET_ADDR: begin
				emit.is_command = 1'b1;
				emit.bus_byte   = CMD_SET_ADDR;
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = action_q ? ST_AUTO_WRITE : ST_PIXEL;
				end
			end
			ST_PIXEL: begin
				emit.is_command = 1'b1;
				emit.bus_byte   = (paint_q ? CMD_BIT_SET : CMD_BIT_CLEAR)
					| {5'd0, 3'd5 - rs_q};
				emit.last       = 1'b1;
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_AUTO_WRITE: begin
				emit.is_command = 1'b1;
				emit.bus_byte   = CMD_AUTO_WRITE;
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_FIRST;
				end
			end
			ST_FIRST: begin
				alu_a = 16'(qs_q);
				alu_b = 16'd1;
				if (qs_q == qe_q) begin
					emit.bus_byte = start_mask & end_mask;
				end else begin
					emit.bus_byte = start_mask;
				end
				if (slot_free) begin
					emit_valid = 1'b1;
					col_load   = 1'b1;
					state_d    = (qs_q == qe_q) ? ST_AUTO_RESET : ST_MID;
				end
			end
			ST_MID: begin
				alu_a         = 16'(col_q);
				alu_b         = 16'd1;
				emit.bus_byte = BYTE_FULL;
				if (col_q < qe_q) begin
					if (slot_free) begin
						emit_valid = 1'b1;
						col_load   = 1'b1;
					end
				end else begin
					state_d = ST_LAST_BYTE;
				end
			end
			ST_LAST_BYTE: begin
				emit.bus_byte = end_mask;
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_AUTO_RESET;
				end
			end
			ST_AUTO_RESET: begin
				emit.is_command = 1'b1;
				emit.bus_byte   = CMD_AUTO_RESET;
				emit.last       = 1'b1;
				if (slot_free) begin
					emit_valid = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/lcd_pixel_and_span_writer_core.sv
// ---------------------------------------------------------------------------
// LCD pixel and span writer
// Turns pixel and horizontal span requests into the byte writes of a graphic
// LCD controller with six pixels per display memory byte.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// request   in         in_valid / in_ready  action, x_start, x_end, row, paint
// writes    out        out_valid/out_ready  is_command, bus_byte, last
// config    in         cfg_we               cfg_index, cfg_wdata
//
// A request is accepted in an idle cycle and the address is then built in
// one step that splits the columns, seven shift-and-add steps on the shared
// adder and one step that adds the column. One beat per cycle follows while
// the output is not stalled: 4 for a pixel, 6 to 45 for a span, plus a step
// that emits no beat, after the middle bytes, for spans of more than one byte.
// in_ready is high only while the sequencer is idle. A stalled output holds
// the sequencer on its current beat. Reset loads the register defaults and
// empties the output register.
`default_nettype none

module lcd_pixel_and_span_writer_core
	import lpsw_pkg::*;
#(
	parameter int WIDTH_PIXELS = WIDTH_PIXELS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  action,
	input  wire logic [7:0]            x_start,
	input  wire logic [7:0]            x_end,
	input  wire logic [6:0]            row,
	input  wire logic                  paint,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       is_command,
	output logic [7:0]                 bus_byte,
	output logic                       last,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [15:0] graphics_base_q;
	logic [7:0]  row_bytes_q;
	logic        out_valid_q;
	beat_t       out_beat_q;
	logic        slot_free;
	logic        emit_valid;
	beat_t       emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			graphics_base_q <= GRAPHICS_BASE_RST;
			row_bytes_q     <= ROW_BYTES_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRAPHICS_BASE: graphics_base_q <= cfg_wdata[15:0];
				REG_ROW_BYTES:     row_bytes_q     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	lpsw_seq #(
		.WIDTH_PIXELS(WIDTH_PIXELS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.x_start      (x_start),
		.x_end        (x_end),
		.row          (row),
		.paint        (paint),
		.graphics_base(graphics_base_q),
		.row_bytes    (row_bytes_q),
		.slot_free    (slot_free),
		.emit_valid   (emit_valid),
		.emit         (emit)
	);

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_valid) begin
			out_beat_q <= emit;
		end
	end

	assign out_valid  = out_valid_q;
	assign is_command = out_beat_q.is_command;
	assign bus_byte   = out_beat_q.bus_byte;
	assign last       = out_beat_q.last;

endmodule

`default_nettype wire

// File: design/lpsw_checker.sv
// ---------------------------------------------------------------------------
// LCD pixel and span writer checker
// Port-level assertions on the request and write channels, bound to the
// top level.
// ---------------------------------------------------------------------------
`default_nettype none

module lpsw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       is_command,
	input wire logic [7:0] bus_byte,
	input wire logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bus_byte)
			&& $stable(is_command) && $stable(last))
		else $error("write beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while the previous one is in progress");

	a_ready_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("ready raised before the final beat of a request");

	a_last_is_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> is_command)
		else $error("final beat of a request is not a command");

endmodule

bind lcd_pixel_and_span_writer_core lpsw_checker u_checker (.*);

`default_nettype wire
